// File: design/gaol_pkg.sv
// ----------------------------------------------------------------------------
// gaol_pkg
// shared types and constants of the grid open-list engine
// ----------------------------------------------------------------------------
package gaol_pkg;

	localparam int ADDR_W     = 12;
	localparam int CELL_COUNT = 4096;
	localparam int G_W        = 12;
	localparam int H_W        = 8;
	localparam int F_W        = 13;
	localparam int CODE_W     = 3;
	localparam int CFG_W      = 7;

	localparam int DEF_ROW_STRIDE = 64;
	localparam int DEF_OPEN_DEPTH = 4096;

	localparam logic [2:0] SEMI_EXTRA = 3'd5;
	localparam logic [2:0] SEMI_BASE  = 3'd1;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_EXPAND = 2'd1,
		REQ_SELECT = 2'd2,
		REQ_REMOVE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2
	} status_t;

	localparam logic [CODE_W-1:0] CODE_FREE    = 3'd0;
	localparam logic [CODE_W-1:0] CODE_SEMI    = 3'd1;
	localparam logic [CODE_W-1:0] CODE_BLOCKER = 3'd2;
	localparam logic [CODE_W-1:0] CODE_OPEN    = 3'd3;
	localparam logic [CODE_W-1:0] CODE_CLOSED  = 3'd4;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_EXP_RD,
		S_EXP_G,
		S_NB_SEL,
		S_NB_RD,
		S_NB_WAIT,
		S_NB_ACT,
		S_SEL_LAST,
		S_SEL_LWAIT,
		S_SEL_LCELL,
		S_SEL_LCWAIT,
		S_SEL_LINIT,
		S_SEL_RD,
		S_SEL_EWAIT,
		S_SEL_CRD,
		S_SEL_CWAIT,
		S_SEL_CMP,
		S_REM_RD,
		S_REM_WAIT,
		S_REM_CMP,
		S_REM_SHRD,
		S_REM_SHWAIT,
		S_REM_SHWR,
		S_OUT
	} state_t;

endpackage

// File: design/gaol_cell_mem.sv
// ----------------------------------------------------------------------------
// gaol_cell_mem
// per-cell store: code, step cost, estimate and parent, one port
// ----------------------------------------------------------------------------
module gaol_cell_mem (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [gaol_pkg::ADDR_W-1:0]          addr,
	input  logic [gaol_pkg::CODE_W-1:0]          wr_code,
	input  logic [gaol_pkg::G_W-1:0]             wr_g,
	input  logic [gaol_pkg::H_W-1:0]             wr_h,
	input  logic [gaol_pkg::ADDR_W-1:0]          wr_parent,
	output logic [gaol_pkg::CODE_W-1:0]          rd_code,
	output logic [gaol_pkg::G_W-1:0]             rd_g,
	output logic [gaol_pkg::H_W-1:0]             rd_h
);

	logic [gaol_pkg::CODE_W-1:0] code_mem   [gaol_pkg::CELL_COUNT];
	logic [gaol_pkg::G_W-1:0]    g_mem      [gaol_pkg::CELL_COUNT];
	logic [gaol_pkg::H_W-1:0]    h_mem      [gaol_pkg::CELL_COUNT];
	logic [gaol_pkg::ADDR_W-1:0] parent_mem [gaol_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			code_mem[addr]   <= wr_code;
			g_mem[addr]      <= wr_g;
			h_mem[addr]      <= wr_h;
			parent_mem[addr] <= wr_parent;
		end
		rd_code <= code_mem[addr];
		rd_g    <= g_mem[addr];
		rd_h    <= h_mem[addr];
	end

endmodule

// File: design/gaol_open_mem.sv
// ----------------------------------------------------------------------------
// gaol_open_mem
// ordered open list store, one port
// ----------------------------------------------------------------------------
module gaol_open_mem #(
	parameter int OPEN_DEPTH = gaol_pkg::DEF_OPEN_DEPTH
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(OPEN_DEPTH)-1:0]     addr,
	input  logic [gaol_pkg::ADDR_W-1:0]       wr_data,
	output logic [gaol_pkg::ADDR_W-1:0]       rd_data
);

	logic [gaol_pkg::ADDR_W-1:0] mem [OPEN_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end

endmodule

// File: design/grid_astar_open_list_engine.sv
// ----------------------------------------------------------------------------
// grid_astar_open_list_engine
// grid A* open-list engine with a Manhattan estimate
// ----------------------------------------------------------------------------
// After reset the engine sweeps the cell store once, one cell a cycle, while
// in_stall stays high. One request beat then gives one result beat, and no
// new request is taken until the current one is done. Load writes the cell on
// accept; expand reads the node and then each neighbour inside the grid; select
// goes straight to the result on an empty list and otherwise reads the last
// entry and then every open entry; remove reads the open entries until the
// address is found and then shifts the later entries down. The single-port
// cell and open-list memories are visited one address per step by the sequencer.
// The result beat sits in an output register, so the engine only waits in its
// output state while the previous result beat is still stalled there.
module grid_astar_open_list_engine #(
	parameter int ROW_STRIDE = gaol_pkg::DEF_ROW_STRIDE,
	parameter int OPEN_DEPTH = gaol_pkg::DEF_OPEN_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [11:0]                   node_index,
	input  logic [11:0]                   target_index,
	input  logic [2:0]                    cell_code,
	input  logic [11:0]                   cost_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [11:0]                   result_index,
	output logic [12:0]                   result_cost,
	output logic [2:0]                    opened_count,
	output logic [1:0]                    status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [6:0]                    cfg_data
);

	localparam int OA_W = $clog2(OPEN_DEPTH);
	localparam int OC_W = $clog2(OPEN_DEPTH + 1);
	localparam int AW   = gaol_pkg::ADDR_W;

	gaol_pkg::state_t state_q, state_d;

	logic [6:0]      gw_q, gh_q;
	logic [OC_W-1:0] cnt_q, cnt_d;
	logic [OC_W-1:0] i_q, i_d;
	logic [AW-1:0]   clr_q, clr_d;
	logic [AW-1:0]   idx_q, idx_d, tgt_q, tgt_d;
	logic [11:0]     gn_q, gn_d;
	logic [2:0]      nb_q, nb_d;
	logic [AW-1:0]   nba_q, nba_d;
	logic [2:0]      opn_q, opn_d;
	logic [AW-1:0]   best_q, best_d, ent_q, ent_d;
	logic [12:0]     val_q, val_d;
	logic [7:0]      lasth_q, lasth_d;
	logic [1:0]      st_q, st_d;
	logic [AW-1:0]   ridx_q, ridx_d;
	logic [12:0]     rcost_q, rcost_d;

	logic            ov_q;
	logic [AW-1:0]   oidx_q;
	logic [12:0]     ocost_q;
	logic [2:0]      oopn_q;
	logic [1:0]      ost_q;
	logic            out_free;

	logic          c_we;
	logic [AW-1:0] c_addr;
	logic [2:0]    c_wcode, c_rcode;
	logic [11:0]   c_wg, c_rg;
	logic [7:0]    c_wh, c_rh;
	logic [AW-1:0] c_wp;
	logic          o_we;
	logic [OA_W-1:0] o_addr;
	logic [AW-1:0] o_wd, o_rd;

	gaol_cell_mem u_cell (
		.clk(clk), .we(c_we), .addr(c_addr), .wr_code(c_wcode), .wr_g(c_wg),
		.wr_h(c_wh), .wr_parent(c_wp), .rd_code(c_rcode), .rd_g(c_rg), .rd_h(c_rh)
	);

	gaol_open_mem #(.OPEN_DEPTH(OPEN_DEPTH)) u_open (
		.clk(clk), .we(o_we), .addr(o_addr), .wr_data(o_wd), .rd_data(o_rd)
	);

	// coordinates
	logic [AW-1:0] x_w, z_w, tx_w, tz_w, nx_w, nz_w;
	logic [AW:0]   dist_w;
	logic [AW:0]   dist_h;
	logic [AW-1:0] nb_addr;
	logic          nb_ok;
	logic [12:0]   f_w;

	assign x_w  = AW'(idx_q % ROW_STRIDE);
	assign z_w  = AW'(idx_q / ROW_STRIDE);
	assign tx_w = AW'(tgt_q % ROW_STRIDE);
	assign tz_w = AW'(tgt_q / ROW_STRIDE);
	assign nx_w = AW'(nba_q % ROW_STRIDE);
	assign nz_w = AW'(nba_q / ROW_STRIDE);
	assign dist_w = ((nx_w > tx_w) ? {1'b0, nx_w - tx_w} : {1'b0, tx_w - nx_w})
		+ ((nz_w > tz_w) ? {1'b0, nz_w - tz_w} : {1'b0, tz_w - nz_w});
	assign dist_h = (c_rcode == gaol_pkg::CODE_SEMI)
		? dist_w + (AW+1)'(gaol_pkg::SEMI_EXTRA - gaol_pkg::SEMI_BASE) : dist_w;
	assign f_w = {1'b0, c_rg} + {5'd0, c_rh};

	always_comb begin
		nb_ok   = 1'b0;
		nb_addr = '0;
		unique case (nb_q[1:0])
			2'd0: begin
				nb_ok   = ({1'b0, z_w} + 13'd1) < {6'd0, gh_q};
				nb_addr = AW'((z_w + 12'd1) * ROW_STRIDE + x_w);
			end
			2'd1: begin
				nb_ok   = z_w != '0;
				nb_addr = AW'((z_w - 12'd1) * ROW_STRIDE + x_w);
			end
			2'd2: begin
				nb_ok   = ({1'b0, x_w} + 13'd1) < {6'd0, gw_q};
				nb_addr = AW'(z_w * ROW_STRIDE + x_w + 12'd1);
			end
			default: begin
				nb_ok   = x_w != '0;
				nb_addr = AW'(z_w * ROW_STRIDE + x_w - 12'd1);
			end
		endcase
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != gaol_pkg::S_IDLE);
	assign out_free  = !ov_q || !out_stall;
	assign out_valid = ov_q;
	assign result_index = oidx_q;
	assign result_cost  = ocost_q;
	assign opened_count = oopn_q;
	assign status       = ost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gaol_pkg::S_CLEAR;
			gw_q    <= 7'd64;
			gh_q    <= 7'd64;
			cnt_q   <= '0;
			clr_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			clr_q   <= clr_d;
			if (state_q == gaol_pkg::S_OUT && out_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == gaol_pkg::CFG_WIDTH) begin
					gw_q <= cfg_data;
				end else begin
					gh_q <= cfg_data;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d; idx_q <= idx_d; tgt_q <= tgt_d;
		gn_q <= gn_d; nb_q <= nb_d;
		nba_q <= nba_d; opn_q <= opn_d; best_q <= best_d; ent_q <= ent_d;
		val_q <= val_d; lasth_q <= lasth_d; st_q <= st_d; ridx_q <= ridx_d;
		rcost_q <= rcost_d;
		if (state_q == gaol_pkg::S_OUT && out_free) begin
			oidx_q  <= ridx_q;
			ocost_q <= rcost_q;
			oopn_q  <= opn_q;
			ost_q   <= st_q;
		end
	end

	always_comb begin
		state_d = state_q; cnt_d = cnt_q; clr_d = clr_q; i_d = i_q;
		idx_d = idx_q; tgt_d = tgt_q;
		gn_d = gn_q; nb_d = nb_q; nba_d = nba_q; opn_d = opn_q;
		best_d = best_q; ent_d = ent_q; val_d = val_q; lasth_d = lasth_q;
		st_d = st_q; ridx_d = ridx_q; rcost_d = rcost_q;
		c_we = 1'b0; c_addr = nba_q; c_wcode = gaol_pkg::CODE_OPEN;
		c_wg = gn_q; c_wh = c_rh; c_wp = idx_q;
		o_we = 1'b0; o_addr = OA_W'(i_q); o_wd = nba_q;
		unique case (state_q)
			gaol_pkg::S_CLEAR: begin
				c_we = 1'b1; c_addr = clr_q;
				c_wcode = gaol_pkg::CODE_FREE; c_wg = '0; c_wh = '0;
				c_wp = clr_q;
				clr_d = clr_q + 1'b1;
				if (clr_q == '1) state_d = gaol_pkg::S_IDLE;
			end
			gaol_pkg::S_IDLE: begin
				if (in_valid) begin
					idx_d = node_index; tgt_d = target_index;
					opn_d = '0; st_d = gaol_pkg::ST_OK; ridx_d = node_index;
					rcost_d = '0; i_d = '0; nb_d = '0;
					unique case (gaol_pkg::req_t'(req_type))
						gaol_pkg::REQ_LOAD: begin
							c_we = 1'b1; c_addr = node_index; c_wcode = cell_code;
							c_wg = cost_value; c_wh = '0; c_wp = node_index;
							state_d = gaol_pkg::S_OUT;
						end
						gaol_pkg::REQ_EXPAND: begin
							c_addr = node_index;
							state_d = gaol_pkg::S_EXP_RD;
						end
						gaol_pkg::REQ_SELECT: begin
							if (cnt_q == '0) begin
								ridx_d = '0; st_d = gaol_pkg::ST_EMPTY;
								state_d = gaol_pkg::S_OUT;
							end else begin
								state_d = gaol_pkg::S_SEL_LAST;
							end
						end
						default: begin
							st_d = gaol_pkg::ST_NOTFOUND;
							state_d = gaol_pkg::S_REM_RD;
						end
					endcase
				end
			end
			gaol_pkg::S_EXP_RD: begin
				c_addr = idx_q;
				state_d = gaol_pkg::S_EXP_G;
			end
			gaol_pkg::S_EXP_G: begin
				gn_d = (c_rg == 12'hFFF) ? c_rg : c_rg + 12'd1;
				state_d = gaol_pkg::S_NB_SEL;
			end
			gaol_pkg::S_NB_SEL: begin
				if (nb_q[2]) begin
					state_d = gaol_pkg::S_OUT;
				end else if (nb_ok) begin
					nba_d = nb_addr;
					state_d = gaol_pkg::S_NB_RD;
				end else begin
					nb_d = nb_q + 3'd1;
				end
			end
			gaol_pkg::S_NB_RD: begin
				state_d = gaol_pkg::S_NB_WAIT;
			end
			gaol_pkg::S_NB_WAIT: begin
				state_d = gaol_pkg::S_NB_ACT;
			end
			gaol_pkg::S_NB_ACT: begin
				nb_d = nb_q + 3'd1;
				state_d = gaol_pkg::S_NB_SEL;
				if (c_rcode == gaol_pkg::CODE_OPEN) begin
					if (gn_q < c_rg) c_we = 1'b1;
				end else if (c_rcode != gaol_pkg::CODE_CLOSED
						&& c_rcode != gaol_pkg::CODE_BLOCKER
						&& cnt_q < OC_W'(OPEN_DEPTH)) begin
					c_we = 1'b1;
					c_wh = (dist_h > 13'd255) ? 8'hFF : dist_h[7:0];
					o_we = 1'b1; o_addr = OA_W'(cnt_q);
					cnt_d = cnt_q + 1'b1;
					opn_d = opn_q + 3'd1;
				end
			end
			gaol_pkg::S_SEL_LAST: begin
				o_addr = OA_W'(cnt_q - 1'b1);
				state_d = gaol_pkg::S_SEL_LWAIT;
			end
			gaol_pkg::S_SEL_LWAIT: begin
				o_addr = OA_W'(cnt_q - 1'b1);
				state_d = gaol_pkg::S_SEL_LCELL;
			end
			gaol_pkg::S_SEL_LCELL: begin
				best_d = o_rd; c_addr = o_rd;
				state_d = gaol_pkg::S_SEL_LCWAIT;
			end
			gaol_pkg::S_SEL_LCWAIT: begin
				c_addr = best_q;
				state_d = gaol_pkg::S_SEL_LINIT;
			end
			gaol_pkg::S_SEL_LINIT: begin
				lasth_d = c_rh; val_d = f_w;
				state_d = gaol_pkg::S_SEL_RD;
			end
			gaol_pkg::S_SEL_RD: begin
				if (i_q == cnt_q) begin
					ridx_d = best_q; rcost_d = val_q;
					state_d = gaol_pkg::S_OUT;
				end else begin
					state_d = gaol_pkg::S_SEL_EWAIT;
				end
			end
			gaol_pkg::S_SEL_EWAIT: begin
				state_d = gaol_pkg::S_SEL_CRD;
			end
			gaol_pkg::S_SEL_CRD: begin
				ent_d = o_rd; c_addr = o_rd;
				state_d = gaol_pkg::S_SEL_CWAIT;
			end
			gaol_pkg::S_SEL_CWAIT: begin
				c_addr = ent_q;
				state_d = gaol_pkg::S_SEL_CMP;
			end
			gaol_pkg::S_SEL_CMP: begin
				if (val_q > f_w || (val_q == f_w && lasth_q > c_rh)) begin
					val_d = f_w; best_d = ent_q;
				end
				i_d = i_q + 1'b1;
				state_d = gaol_pkg::S_SEL_RD;
			end
			gaol_pkg::S_REM_RD: begin
				if (i_q == cnt_q) begin
					state_d = gaol_pkg::S_OUT;
				end else begin
					state_d = gaol_pkg::S_REM_WAIT;
				end
			end
			gaol_pkg::S_REM_WAIT: begin
				state_d = gaol_pkg::S_REM_CMP;
			end
			gaol_pkg::S_REM_CMP: begin
				if (o_rd == idx_q) begin
					st_d = gaol_pkg::ST_OK;
					state_d = gaol_pkg::S_REM_SHRD;
				end else begin
					i_d = i_q + 1'b1;
					state_d = gaol_pkg::S_REM_RD;
				end
			end
			gaol_pkg::S_REM_SHRD: begin
				if (i_q + 1'b1 >= cnt_q) begin
					cnt_d = cnt_q - 1'b1;
					state_d = gaol_pkg::S_OUT;
				end else begin
					o_addr = OA_W'(i_q + 1'b1);
					state_d = gaol_pkg::S_REM_SHWAIT;
				end
			end
			gaol_pkg::S_REM_SHWAIT: begin
				o_addr = OA_W'(i_q + 1'b1);
				state_d = gaol_pkg::S_REM_SHWR;
			end
			gaol_pkg::S_REM_SHWR: begin
				o_we = 1'b1; o_wd = o_rd;
				i_d = i_q + 1'b1;
				state_d = gaol_pkg::S_REM_SHRD;
			end
			default: begin
				if (out_free) state_d = gaol_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid open-list engine. It runs a directed table,
// then random load, expand, select and remove beats over several grid sizes.
// Each accepted request beat is run through a local model of the grid and the
// open list. Each result beat is compared field by field with the oldest
// expected result.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [11:0]       idx;
		logic [12:0]       cost;
		logic [2:0]        opened;
		gaol_pkg::status_t st;
	} result_t;

	typedef struct packed {
		gaol_pkg::req_t req;
		logic [11:0]    node;
		logic [11:0]    tgt;
		logic [2:0]     code;
		logic [11:0]    cost;
		bit             typed;
		result_t        want;
	} beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [11:0] node_index;
	logic [11:0] target_index;
	logic [2:0]  cell_code;
	logic [11:0] cost_value;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] result_index;
	logic [12:0] result_cost;
	logic [2:0]  opened_count;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	grid_astar_open_list_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .node_index(node_index), .target_index(target_index),
		.cell_code(cell_code), .cost_value(cost_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_index(result_index), .result_cost(result_cost),
		.opened_count(opened_count), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// local copy of the grid and open list
	logic [2:0]  cell_st [gaol_pkg::CELL_COUNT];
	logic [11:0] cell_g  [gaol_pkg::CELL_COUNT];
	logic [7:0]  cell_h  [gaol_pkg::CELL_COUNT];
	logic [11:0] open_q  [$];
	int          cols;
	int          rows;

	result_t     pending_q [$];
	int          errors;
	bit          no_idle;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	task automatic report(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	function automatic bit open_cell(int nb, int from, int gn, int tx, int tz);
		int span;
		if (cell_st[nb] == gaol_pkg::CODE_OPEN) begin
			if (gn < cell_g[nb])
				cell_g[nb] = gn[11:0];
			return 0;
		end
		if (cell_st[nb] == gaol_pkg::CODE_CLOSED || cell_st[nb] == gaol_pkg::CODE_BLOCKER)
			return 0;
		if (open_q.size() >= gaol_pkg::DEF_OPEN_DEPTH)
			return 0;
		span = ((nb % 64 > tx) ? nb % 64 - tx : tx - nb % 64)
			+ ((nb / 64 > tz) ? nb / 64 - tz : tz - nb / 64);
		if (cell_st[nb] == gaol_pkg::CODE_SEMI)
			span += int'(gaol_pkg::SEMI_EXTRA) - int'(gaol_pkg::SEMI_BASE);
		if (span > 255)
			span = 255;
		cell_g[nb] = gn[11:0];
		cell_h[nb] = span[7:0];
		cell_st[nb] = gaol_pkg::CODE_OPEN;
		open_q = {open_q, nb[11:0]};
		return 1;
	endfunction

	function automatic result_t step_grid(beat_t b);
		result_t r;
		int x, z, tx, tz, gn, n, best, lh, val, f;
		r = '{idx: b.node, cost: '0, opened: '0, st: gaol_pkg::ST_OK};
		case (b.req)
			gaol_pkg::REQ_LOAD: begin
				cell_st[b.node] = b.code;
				cell_g[b.node] = b.cost;
				cell_h[b.node] = '0;
			end
			gaol_pkg::REQ_EXPAND: begin
				x = b.node % 64;
				z = b.node / 64;
				tx = b.tgt % 64;
				tz = b.tgt / 64;
				gn = cell_g[b.node] + 1;
				if (gn > 4095)
					gn = 4095;
				n = 0;
				if (z + 1 < rows)
					n += open_cell(((z + 1) * 64 + x) & 12'hFFF, b.node, gn, tx, tz);
				if (z >= 1)
					n += open_cell(((z - 1) * 64 + x) & 12'hFFF, b.node, gn, tx, tz);
				if (x + 1 < cols)
					n += open_cell((z * 64 + x + 1) & 12'hFFF, b.node, gn, tx, tz);
				if (x >= 1)
					n += open_cell((z * 64 + x - 1) & 12'hFFF, b.node, gn, tx, tz);
				r.opened = n[2:0];
			end
			gaol_pkg::REQ_SELECT: begin
				if (open_q.size() == 0) begin
					r.idx = '0;
					r.st = gaol_pkg::ST_EMPTY;
				end else begin
					best = open_q[$];
					lh = cell_h[best];
					val = cell_g[best] + lh;
					foreach (open_q[i]) begin
						f = cell_g[open_q[i]] + cell_h[open_q[i]];
						if (val > f || (val == f && lh > cell_h[open_q[i]])) begin
							val = f;
							best = open_q[i];
						end
					end
					r.idx = best[11:0];
					r.cost = val[12:0];
				end
			end
			default: begin
				r.st = gaol_pkg::ST_NOTFOUND;
				foreach (open_q[i]) begin
					if (open_q[i] == b.node) begin
						open_q.delete(i);
						r.st = gaol_pkg::ST_OK;
						break;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic send_req(input beat_t b);
		int gap;
		result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= b.req;
		node_index <= b.node;
		target_index <= b.tgt;
		cell_code <= b.code;
		cost_value <= b.cost;
		do @(posedge clk); while (in_stall);
		r = step_grid(b);
		pending_q = {pending_q, (b.typed ? b.want : r)};
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == gaol_pkg::CFG_WIDTH)
			cols = int'(val);
		else
			rows = int'(val);
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic beat_t random_req();
		beat_t b;
		int pick, bx, bz;
		b = '0;
		pick = $urandom_range(0, 99);
		b.req = pick < 25 ? gaol_pkg::REQ_LOAD : pick < 60 ? gaol_pkg::REQ_EXPAND
			: pick < 85 ? gaol_pkg::REQ_SELECT : gaol_pkg::REQ_REMOVE;
		bx = $urandom_range(0, 1) ? 0 : 56;
		bz = $urandom_range(0, 1) ? 0 : 56;
		if ($urandom_range(0, 9) == 0)
			b.node = 12'($urandom_range(0, 4095));
		else
			b.node = 12'(((bz + $urandom_range(0, 7)) << 6) | (bx + $urandom_range(0, 7)));
		b.tgt = $urandom_range(0, 3) == 0 ? 12'($urandom_range(0, 4095)) : b.node ^ 12'h0C3;
		b.code = $urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7)) : gaol_pkg::CODE_FREE;
		b.cost = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095))
			: 12'($urandom_range(0, 15));
		if (b.req == gaol_pkg::REQ_REMOVE && open_q.size() != 0 && $urandom_range(0, 4) != 0)
			b.node = open_q[$urandom_range(0, open_q.size() - 1)];
		return b;
	endfunction

	beat_t dir_tab [] = '{
		'{gaol_pkg::REQ_SELECT, 12'd0, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b1,
			'{12'd0, 13'd0, 3'd0, gaol_pkg::ST_EMPTY}},
		'{gaol_pkg::REQ_REMOVE, 12'd5, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b1,
			'{12'd5, 13'd0, 3'd0, gaol_pkg::ST_NOTFOUND}},
		'{gaol_pkg::REQ_LOAD, 12'd4095, 12'd0, 3'd7, 12'd4095, 1'b1,
			'{12'd4095, 13'd0, 3'd0, gaol_pkg::ST_OK}},
		'{gaol_pkg::REQ_LOAD, 12'd0, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b1,
			'{12'd0, 13'd0, 3'd0, gaol_pkg::ST_OK}},
		'{gaol_pkg::REQ_LOAD, 12'd1, 12'd0, gaol_pkg::CODE_SEMI, 12'd0, 1'b1,
			'{12'd1, 13'd0, 3'd0, gaol_pkg::ST_OK}},
		'{gaol_pkg::REQ_LOAD, 12'd64, 12'd0, gaol_pkg::CODE_BLOCKER, 12'd9, 1'b1,
			'{12'd64, 13'd0, 3'd0, gaol_pkg::ST_OK}},
		'{gaol_pkg::REQ_EXPAND, 12'd0, 12'd4095, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_LOAD, 12'd4094, 12'd0, gaol_pkg::CODE_CLOSED, 12'd0, 1'b1,
			'{12'd4094, 13'd0, 3'd0, gaol_pkg::ST_OK}},
		'{gaol_pkg::REQ_LOAD, 12'd4031, 12'd0, gaol_pkg::CODE_OPEN, 12'd4095, 1'b1,
			'{12'd4031, 13'd0, 3'd0, gaol_pkg::ST_OK}},
		'{gaol_pkg::REQ_EXPAND, 12'd4095, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_LOAD, 12'd2, 12'd0, 3'd5, 12'd100, 1'b0, '0},
		'{gaol_pkg::REQ_LOAD, 12'd65, 12'd0, 3'd6, 12'd7, 1'b0, '0},
		'{gaol_pkg::REQ_EXPAND, 12'd1, 12'd2, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_SELECT, 12'd0, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_REMOVE, 12'd1, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_REMOVE, 12'd1, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_SELECT, 12'd0, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_LOAD, 12'd2050, 12'd0, gaol_pkg::CODE_OPEN, 12'd4000, 1'b0, '0},
		'{gaol_pkg::REQ_LOAD, 12'd2051, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_EXPAND, 12'd2051, 12'd2051, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_SELECT, 12'd0, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b0, '0},
		'{gaol_pkg::REQ_REMOVE, 12'd4095, 12'd0, gaol_pkg::CODE_FREE, 12'd0, 1'b1,
			'{12'd4095, 13'd0, 3'd0, gaol_pkg::ST_NOTFOUND}}
	};

	int widths  [6] = '{64, 8, 0, 127, 1, 64};
	int heights [6] = '{64, 6, 0, 127, 64, 1};

	initial begin
		errors = 0;
		no_idle = 1'b0;
		cols = 64;
		rows = 64;
		foreach (cell_st[i]) begin
			cell_st[i] = gaol_pkg::CODE_FREE;
			cell_g[i] = '0;
			cell_h[i] = '0;
		end
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = '0;
		node_index = '0;
		target_index = '0;
		cell_code = '0;
		cost_value = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_req(dir_tab[i]);
		in_valid <= 1'b0;
		drain();
		for (int p = 0; p < 6; p++) begin
			write_reg(gaol_pkg::CFG_WIDTH, 7'(widths[p]));
			write_reg(gaol_pkg::CFG_HEIGHT, 7'(heights[p]));
			no_idle = (p % 3 == 1);
			repeat (20) send_req(random_req());
			in_valid <= 1'b0;
			drain();
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side back-pressure
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 6);
			out_stall <= (n != 0);
			repeat (n) @(posedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		result_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				w = pending_q.pop_front();
				if (result_index !== w.idx)
					report($sformatf("result_index %0d, want %0d", result_index, w.idx));
				if (result_cost !== w.cost)
					report($sformatf("result_cost %0d, want %0d", result_cost, w.cost));
				if (opened_count !== w.opened)
					report($sformatf("opened_count %0d, want %0d", opened_count, w.opened));
				if (status !== w.st)
					report($sformatf("status %0d, want %0d", status, w.st));
			end
		end
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: grid_astar_open_list_engine.f
design/gaol_pkg.sv
design/gaol_cell_mem.sv
design/gaol_open_mem.sv
design/grid_astar_open_list_engine.sv
sim/tb_top.sv
